FILE: rtl/vch_pkg.sv
// Package for the vector clock with holes: item types and mode codes.
`default_nettype none

package vch_pkg;

    localparam int unsigned HOLE_W = 64;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned END_W = 7;
    localparam int unsigned TID_W = 3;
    localparam int unsigned MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONTAINS     = 3'd0,
        MODE_ADD_HOLE     = 3'd1,
        MODE_REMOVE_HOLE  = 3'd2,
        MODE_CLEAR_THREAD = 3'd3,
        MODE_ADD_RANGE    = 3'd4,
        MODE_REMOVE_RANGE = 3'd5,
        MODE_MERGE_ROW    = 3'd6
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TID_W-1:0]   thread_id;
        logic [INDEX_W-1:0] event_index;
        logic [END_W-1:0]   range_end;
        logic [INDEX_W-1:0] other_max;
        logic [HOLE_W-1:0]  other_holes;
    } cmd_t;

    typedef struct packed {
        logic               contained;
        logic               bad_hole;
        logic [INDEX_W-1:0] row_max;
        logic [HOLE_W-1:0]  row_holes;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/vector_clock_with_holes_top.sv
// Top level of the vector clock with holes: row store, update logic and result register.
//
//  channel   ports                 direction  accepted when
//  command   start, busy, cmd      in         start && !busy at a rising edge
//  result    done, result          out        done high, one cycle, no back-pressure
//
// An item is taken into an input register, and at the next edge its row is read,
// updated and written back while the result register loads: one item per cycle
// sustained, busy is always low.
// The row store (one max and one hole bitmap per thread, in flip-flops) sets the
// throughput: the read-modify-write of one row is combinational from the input register.
// Reset clears every row to maximum 0 with no holes; the receiver cannot stall.
`default_nettype none

module vector_clock_with_holes_top #(
    parameter int unsigned THREADS = 8,
    parameter int unsigned EVENTS = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire vch_pkg::cmd_t   cmd,
    output logic                 done,
    output vch_pkg::result_t     result
);

    // thread_id is three bits wide, so no more than eight rows are reachable
    localparam int unsigned ROWS = (THREADS < 8) ? THREADS : 8;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [vch_pkg::HOLE_W-1:0] EMASK =
        {vch_pkg::HOLE_W{1'b1}} >> (vch_pkg::HOLE_W - EVENTS);
    localparam logic [vch_pkg::INDEX_W-1:0] EV_LAST = vch_pkg::INDEX_W'(EVENTS - 1);
    localparam logic [vch_pkg::END_W-1:0]   EV_END  = vch_pkg::END_W'(EVENTS);
    localparam logic [vch_pkg::END_W-1:0]   THR_LIM = vch_pkg::END_W'(THREADS);

    logic [vch_pkg::INDEX_W-1:0] max_reg   [ROWS];
    logic [vch_pkg::HOLE_W-1:0]  holes_reg [ROWS];

    vch_pkg::cmd_t    cmd_reg;
    logic             cmd_valid_reg;
    vch_pkg::result_t result_reg;
    vch_pkg::result_t result_next;
    logic             done_reg;

    logic                        row_ok;
    logic [ROW_W-1:0]            row_idx;
    logic [vch_pkg::INDEX_W-1:0] m_next;
    logic [vch_pkg::HOLE_W-1:0]  h_next;

    function automatic logic [vch_pkg::HOLE_W-1:0] bits_below(
        input logic [vch_pkg::END_W-1:0] n
    );
        logic [vch_pkg::HOLE_W-1:0] r;
        if (n >= vch_pkg::END_W'(vch_pkg::HOLE_W))
            r = {vch_pkg::HOLE_W{1'b1}};
        else
            r = (vch_pkg::HOLE_W'(1) << n) - vch_pkg::HOLE_W'(1);
        return r;
    endfunction

    function automatic logic [vch_pkg::HOLE_W-1:0] bits_above(
        input logic [vch_pkg::INDEX_W-1:0] m
    );
        logic [vch_pkg::HOLE_W-1:0] r;
        if (m == {vch_pkg::INDEX_W{1'b1}})
            r = '0;
        else
            r = {vch_pkg::HOLE_W{1'b1}} << ({1'b0, m} + vch_pkg::END_W'(1));
        return r;
    endfunction

    assign busy = 1'b0;

    always_comb
    begin
        logic [vch_pkg::INDEX_W-1:0] m;
        logic [vch_pkg::HOLE_W-1:0]  h;
        logic [vch_pkg::INDEX_W-1:0] idx;
        logic [vch_pkg::END_W-1:0]   rend;
        logic [vch_pkg::INDEX_W-1:0] omax;
        logic [vch_pkg::HOLE_W-1:0]  oholes;
        logic [vch_pkg::HOLE_W-1:0]  span;
        logic                        contained;
        logic                        bad;

        row_ok  = {4'b0, cmd_reg.thread_id} < THR_LIM;
        row_idx = row_ok ? ROW_W'(cmd_reg.thread_id) : '0;
        m       = row_ok ? max_reg[row_idx] : '0;
        h       = row_ok ? holes_reg[row_idx] : '0;
        idx     = cmd_reg.event_index;
        rend    = (cmd_reg.range_end > EV_END) ? EV_END : cmd_reg.range_end;
        omax    = (cmd_reg.other_max > EV_LAST) ? EV_LAST : cmd_reg.other_max;
        oholes  = cmd_reg.other_holes & EMASK;
        span    = bits_below(rend) & ~bits_below({1'b0, idx});
        contained = 1'b0;
        bad       = 1'b0;

        case (cmd_reg.mode)
            vch_pkg::MODE_CONTAINS:
            begin
                contained = (idx <= m) && ((idx == '0) || !h[idx]);
            end
            vch_pkg::MODE_ADD_HOLE:
            begin
                if (idx > m)
                    bad = 1'b1;
                else
                    h = h | ((vch_pkg::HOLE_W'(1) << idx) & EMASK);
            end
            vch_pkg::MODE_REMOVE_HOLE:
            begin
                h = h & ~(vch_pkg::HOLE_W'(1) << idx);
            end
            vch_pkg::MODE_CLEAR_THREAD:
            begin
                h = '0;
            end
            vch_pkg::MODE_ADD_RANGE:
            begin
                if ({1'b0, idx} < rend)
                begin
                    if ((rend - vch_pkg::END_W'(1)) > {1'b0, m})
                        bad = 1'b1;
                    else
                        h = h | span;
                end
            end
            vch_pkg::MODE_REMOVE_RANGE:
            begin
                if ({1'b0, idx} < rend)
                    h = h & ~span;
            end
            vch_pkg::MODE_MERGE_ROW:
            begin
                // keep common holes, plus the larger row's holes above the smaller max
                if (m < omax)
                begin
                    h = (h & oholes) | (oholes & bits_above(m));
                    m = omax;
                end
                else
                begin
                    h = (h & oholes) | (h & bits_above(omax));
                end
            end
            default:
            begin
            end
        endcase

        h = h & EMASK;
        if (!row_ok)
        begin
            m = '0;
            h = '0;
        end
        m_next = m;
        h_next = h;

        result_next.contained = contained;
        result_next.bad_hole  = bad;
        result_next.row_max   = m;
        result_next.row_holes = h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                max_reg[i]   <= '0;
                holes_reg[i] <= '0;
            end
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
            done_reg      <= cmd_valid_reg;
            if (cmd_valid_reg && row_ok)
            begin
                max_reg[row_idx]   <= m_next;
                holes_reg[row_idx] <= h_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
        if (cmd_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
